@@ rtl/gcoq_pkg.sv @@
// Shared types and constants for the grid cell openness query block.
// Used by the top level, the walker, the evaluator and the checker; depends on nothing.
package gcoq_pkg;

  localparam int MAX_GRID_W = 64;
  localparam int MAX_GRID_H = 64;
  localparam int CELLS      = MAX_GRID_W * MAX_GRID_H;
  localparam int ADDR_W     = $clog2(CELLS);

  // Field widths fixed by the item and register formats.
  localparam int POS_W  = 6;   // cell_x, cell_y
  localparam int DIM_W  = 7;   // grid_width, grid_height
  localparam int OPN_W  = 8;   // max_openness, openness
  localparam int RING_W = 8;   // ring radius, up to 128
  localparam int CRD_W  = 9;   // signed cell coordinate around a ring
  localparam int IN_DW  = 16;  // s_axis_tdata width
  localparam int CFG_AW = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_AW-1:0] REG_GRID_W   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_GRID_H   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_OPEN = 2'd2;

  // Item kinds carried on s_axis_tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Which part of a ring a visited cell belongs to, in visiting order.
  typedef enum logic [3:0] {
    PH_CENTER,
    PH_TOP,
    PH_BOT,
    PH_LEFT,
    PH_RIGHT,
    PH_TL,
    PH_TR,
    PH_BL,
    PH_BR
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [RING_W-1:0]  ring;
  } cell_tag_t;

  typedef struct packed {
    logic              done;
    logic [OPN_W-1:0]  value;
  } eval_res_t;

endpackage

@@ rtl/grid_cell_openness_query.sv @@
// Top level of the grid cell openness query block: control sequencer, bitmap,
// configuration registers and output register. Depends on gcoq_pkg, gcoq_ram,
// gcoq_ring_walk and gcoq_ring_eval.
//
//   Channel     Dir  Width  Contents
//   s_axis      in   16+1   tdata: cell_x, cell_y, solid; tuser: cmd
//   m_axis      out  8      tdata: openness
//   cfg         in   2+8    index and data of grid_width, grid_height, max_openness
//
// A write item, and a query with max_openness of 0, passes through the done
// state into the output register. Any other query visits the centre cell and
// then 8r cells for each ring r it scans, one cell per cycle through the
// single read port of the bitmap; a scan can stop partway through a ring.
// After reset all 4096 cells of the bitmap are cleared, one cell per cycle,
// while no item is accepted; configuration writes are taken throughout.
// A result waits in the output register while m_axis_tready is low; the block
// then accepts the next item and holds its result until the register frees.
module grid_cell_openness_query (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gcoq_pkg::IN_DW-1:0]    s_axis_tdata,  // cell_x, cell_y, solid, zero fill
  input  logic [0:0]                    s_axis_tuser,  // cmd
  // Result items.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [gcoq_pkg::OPN_W-1:0]    m_axis_tdata,  // openness
  // Configuration writes.
  input  logic                          cfg_we_i,
  input  logic [gcoq_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [gcoq_pkg::OPN_W-1:0]    cfg_wdata_i
);
  import gcoq_pkg::*;

  state_e state_q, state_d;

  // Configuration registers.
  logic [DIM_W-1:0] grid_w_q, grid_h_q;
  logic [OPN_W-1:0] max_open_q;
  logic [DIM_W-1:0] eff_w, eff_h;
  logic [RING_W-1:0] max_ring;

  // Input item fields.
  logic             in_cmd;
  logic [POS_W-1:0] in_x, in_y;
  logic             in_solid;
  logic             in_accept;

  // Bitmap clearing sweep.
  logic [ADDR_W-1:0] clr_q;
  logic              clr_last;

  // Bitmap ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [0:0]        ram_wdata;
  logic [0:0]        ram_rdata;
  logic              wr_in_store;

  // Walker and check stage.
  logic              walk_start;
  logic              walk_valid, walk_inb;
  logic [ADDR_W-1:0] walk_addr;
  cell_tag_t         walk_tag;
  logic              chk_valid_q;
  logic              chk_inb_q;
  cell_tag_t         chk_tag_q;
  eval_res_t         eval_res;

  // Result holding and output register.
  logic [OPN_W-1:0] res_q;
  logic             out_free;
  logic             out_load;
  logic [OPN_W-1:0] out_data_q;
  logic             out_valid_q;

  assign in_cmd   = s_axis_tuser[0];
  assign in_x     = s_axis_tdata[POS_W-1:0];
  assign in_y     = s_axis_tdata[2*POS_W-1:POS_W];
  assign in_solid = s_axis_tdata[2*POS_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Grid dimensions beyond the store are clamped to it.
  assign eff_w = (32'(grid_w_q) > MAX_GRID_W) ? DIM_W'(MAX_GRID_W) : grid_w_q;
  assign eff_h = (32'(grid_h_q) > MAX_GRID_H) ? DIM_W'(MAX_GRID_H) : grid_h_q;
  assign max_ring = RING_W'(({1'b0, max_open_q} + (OPN_W+1)'(1)) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q   <= DIM_W'(64);
      grid_h_q   <= DIM_W'(64);
      max_open_q <= OPN_W'(8);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_GRID_W:   grid_w_q   <= cfg_wdata_i[DIM_W-1:0];
        REG_GRID_H:   grid_h_q   <= cfg_wdata_i[DIM_W-1:0];
        REG_MAX_OPEN: max_open_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state.
  assign clr_last = (clr_q == ADDR_W'(CELLS - 1));
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (in_cmd == CMD_QUERY && max_open_q != '0) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (eval_res.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    walk_start    = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        walk_start    = s_axis_tvalid && in_cmd == CMD_QUERY && max_open_q != '0;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // Writes outside the store are dropped; the sweep owns the write port first.
  assign wr_in_store = (32'(in_x) < MAX_GRID_W) && (32'(in_y) < MAX_GRID_H);
  assign ram_we    = (state_q == ST_CLEAR) ||
                     (in_accept && in_cmd == CMD_WRITE && wr_in_store);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q :
                     ADDR_W'(ADDR_W'(in_y) * ADDR_W'(MAX_GRID_W)) + ADDR_W'(in_x);
  assign ram_wdata = (state_q == ST_CLEAR) ? 1'b0 : in_solid;

  gcoq_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (walk_addr),
    .rdata_o (ram_rdata)
  );

  gcoq_ring_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .stop_i  (eval_res.done),
    .cx_i    (in_x),
    .cy_i    (in_y),
    .eff_w_i (eff_w),
    .eff_h_i (eff_h),
    .valid_o (walk_valid),
    .inb_o   (walk_inb),
    .addr_o  (walk_addr),
    .tag_o   (walk_tag)
  );

  // The check stage lines a visited cell up with its bitmap read. When the
  // scan ends, the cell issued in the same cycle is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_valid_q <= 1'b0;
    end else begin
      chk_valid_q <= walk_valid && !eval_res.done;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_inb_q <= walk_inb;
    chk_tag_q <= walk_tag;
  end

  gcoq_ring_eval u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (walk_start),
    .valid_i    (chk_valid_q),
    .tag_i      (chk_tag_q),
    .solid_i    (!chk_inb_q || ram_rdata[0]),
    .max_ring_i (max_ring),
    .res_o      (eval_res)
  );

  // The finished value waits in res_q until the output register frees up.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= '0;
    end else if (state_q == ST_SCAN && eval_res.done) begin
      res_q <= eval_res.value;
    end
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/gcoq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Holds the solid-cell bitmap; no dependencies.
module gcoq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/gcoq_ring_walk.sv @@
// Cell walker: steps one coordinate pair per cycle over the centre and then
// ring after ring around it. Depends on gcoq_pkg.
module gcoq_ring_walk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          stop_i,
  input  logic [gcoq_pkg::POS_W-1:0]    cx_i,
  input  logic [gcoq_pkg::POS_W-1:0]    cy_i,
  input  logic [gcoq_pkg::DIM_W-1:0]    eff_w_i,
  input  logic [gcoq_pkg::DIM_W-1:0]    eff_h_i,
  output logic                          valid_o,
  output logic                          inb_o,
  output logic [gcoq_pkg::ADDR_W-1:0]   addr_o,
  output gcoq_pkg::cell_tag_t           tag_o
);
  import gcoq_pkg::*;

  logic                     run_q, run_d;
  phase_e                   phase_q, phase_d;
  logic [RING_W-1:0]        r_q, r_d;
  logic signed [CRD_W-1:0]  x_q, x_d, y_q, y_d;
  logic signed [CRD_W-1:0]  lox_q, lox_d, hix_q, hix_d;
  logic signed [CRD_W-1:0]  loy_q, loy_d, hiy_q, hiy_d;
  logic signed [CRD_W-1:0]  x_inc, y_inc;
  logic signed [CRD_W-1:0]  cx_s, cy_s;

  assign cx_s  = $signed({{(CRD_W-POS_W){1'b0}}, cx_i});
  assign cy_s  = $signed({{(CRD_W-POS_W){1'b0}}, cy_i});
  assign x_inc = x_q + CRD_W'(1);
  assign y_inc = y_q + CRD_W'(1);

  always_comb begin
    run_d   = run_q;
    phase_d = phase_q;
    r_d     = r_q;
    x_d     = x_q;
    y_d     = y_q;
    lox_d   = lox_q;
    hix_d   = hix_q;
    loy_d   = loy_q;
    hiy_d   = hiy_q;
    if (start_i) begin
      run_d   = 1'b1;
      phase_d = PH_CENTER;
      r_d     = '0;
      x_d     = cx_s;
      y_d     = cy_s;
      lox_d   = cx_s - CRD_W'(1);
      hix_d   = cx_s + CRD_W'(1);
      loy_d   = cy_s - CRD_W'(1);
      hiy_d   = cy_s + CRD_W'(1);
    end else if (stop_i) begin
      run_d = 1'b0;
    end else if (run_q) begin
      case (phase_q)
        PH_CENTER: begin
          phase_d = PH_TOP;
          r_d     = RING_W'(1);
          x_d     = lox_q + CRD_W'(1);
          y_d     = loy_q;
        end
        PH_TOP: begin
          if (x_inc == hix_q) begin
            phase_d = PH_BOT;
            x_d     = lox_q + CRD_W'(1);
            y_d     = hiy_q;
          end else begin
            x_d = x_inc;
          end
        end
        PH_BOT: begin
          if (x_inc == hix_q) begin
            phase_d = PH_LEFT;
            x_d     = lox_q;
            y_d     = loy_q + CRD_W'(1);
          end else begin
            x_d = x_inc;
          end
        end
        PH_LEFT: begin
          phase_d = PH_RIGHT;
          x_d     = hix_q;
        end
        PH_RIGHT: begin
          x_d = lox_q;
          if (y_inc == hiy_q) begin
            phase_d = PH_TL;
            y_d     = loy_q;
          end else begin
            phase_d = PH_LEFT;
            y_d     = y_inc;
          end
        end
        PH_TL: begin
          phase_d = PH_TR;
          x_d     = hix_q;
        end
        PH_TR: begin
          phase_d = PH_BL;
          x_d     = lox_q;
          y_d     = hiy_q;
        end
        PH_BL: begin
          phase_d = PH_BR;
          x_d     = hix_q;
        end
        PH_BR: begin
          // Grow the ring by one cell on every side and start its top row.
          phase_d = PH_TOP;
          r_d     = r_q + RING_W'(1);
          lox_d   = lox_q - CRD_W'(1);
          hix_d   = hix_q + CRD_W'(1);
          loy_d   = loy_q - CRD_W'(1);
          hiy_d   = hiy_q + CRD_W'(1);
          x_d     = lox_q;
          y_d     = loy_q - CRD_W'(1);
        end
        default: begin
          run_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    r_q     <= r_d;
    x_q     <= x_d;
    y_q     <= y_d;
    lox_q   <= lox_d;
    hix_q   <= hix_d;
    loy_q   <= loy_d;
    hiy_q   <= hiy_d;
  end

  // Cells off the grid in use read as solid whatever the bitmap holds.
  assign inb_o = !x_q[CRD_W-1] && !y_q[CRD_W-1] &&
                 (x_q[CRD_W-2:0] < (CRD_W-1)'(eff_w_i)) &&
                 (y_q[CRD_W-2:0] < (CRD_W-1)'(eff_h_i));
  assign addr_o = ADDR_W'(ADDR_W'(y_q[POS_W-1:0]) * ADDR_W'(MAX_GRID_W)) +
                  ADDR_W'(x_q[POS_W-1:0]);
  assign valid_o   = run_q;
  assign tag_o.phase = phase_q;
  assign tag_o.ring  = r_q;

endmodule

@@ rtl/gcoq_ring_eval.sv @@
// Ring evaluator: folds the solid bit of each visited cell into the side and
// corner flags of the current ring and decides when the scan ends.
// Depends on gcoq_pkg.
module gcoq_ring_eval (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        valid_i,
  input  gcoq_pkg::cell_tag_t         tag_i,
  input  logic                        solid_i,
  input  logic [gcoq_pkg::RING_W-1:0] max_ring_i,
  output gcoq_pkg::eval_res_t         res_o
);
  import gcoq_pkg::*;

  logic top_q, bot_q, lft_q, rgt_q, tl_q, tr_q, bl_q;
  logic top_d, bot_d, lft_d, rgt_d, tl_d, tr_d, bl_d;
  logic all_c, occ, ext;
  logic [OPN_W-1:0] base;
  logic [OPN_W-1:0] full;

  // 2r-1 for the ring of this cell, and 2*maxRing-1 when no ring is hit.
  assign base = OPN_W'({1'b0, tag_i.ring, 1'b0} - (RING_W+2)'(1));
  assign full = OPN_W'({1'b0, max_ring_i, 1'b0} - (RING_W+2)'(1));
  assign all_c = tl_q && tr_q && bl_q && solid_i;
  assign occ   = top_q || bot_q || lft_q || rgt_q || tl_q || tr_q || bl_q || solid_i;
  assign ext   = !all_c && ((!tl_q && !top_q && !lft_q) || (!tr_q && !top_q && !rgt_q) ||
                            (!bl_q && !bot_q && !lft_q) || (!solid_i && !bot_q && !rgt_q));

  always_comb begin
    res_o = '0;
    top_d = top_q;
    bot_d = bot_q;
    lft_d = lft_q;
    rgt_d = rgt_q;
    tl_d  = tl_q;
    tr_d  = tr_q;
    bl_d  = bl_q;
    if (valid_i) begin
      case (tag_i.phase)
        PH_CENTER: begin
          if (solid_i) begin
            res_o.done = 1'b1;
          end else if (max_ring_i == RING_W'(1)) begin
            res_o.done  = 1'b1;
            res_o.value = full;
          end
        end
        PH_TOP: begin
          if (solid_i) top_d = 1'b1;
        end
        PH_BOT: begin
          if (solid_i) begin
            bot_d = 1'b1;
            if (top_q) begin
              res_o.done  = 1'b1;
              res_o.value = base;
            end
          end
        end
        PH_LEFT: begin
          if (solid_i) begin
            lft_d = 1'b1;
            if (rgt_q) begin
              res_o.done  = 1'b1;
              res_o.value = base;
            end
          end
        end
        PH_RIGHT: begin
          if (solid_i) begin
            rgt_d = 1'b1;
            if (lft_q) begin
              res_o.done  = 1'b1;
              res_o.value = base;
            end
          end
        end
        PH_TL: tl_d = solid_i;
        PH_TR: tr_d = solid_i;
        PH_BL: bl_d = solid_i;
        PH_BR: begin
          if (occ) begin
            res_o.done  = 1'b1;
            res_o.value = base + OPN_W'(ext);
          end else if ((tag_i.ring + RING_W'(1)) == max_ring_i) begin
            res_o.done  = 1'b1;
            res_o.value = full;
          end
          // The next ring starts with clean flags.
          top_d = 1'b0;
          bot_d = 1'b0;
          lft_d = 1'b0;
          rgt_d = 1'b0;
          tl_d  = 1'b0;
          tr_d  = 1'b0;
          bl_d  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {top_q, bot_q, lft_q, rgt_q, tl_q, tr_q, bl_q} <= '0;
    end else if (clear_i) begin
      {top_q, bot_q, lft_q, rgt_q, tl_q, tr_q, bl_q} <= '0;
    end else begin
      {top_q, bot_q, lft_q, rgt_q, tl_q, tr_q, bl_q} <=
        {top_d, bot_d, lft_d, rgt_d, tl_d, tr_d, bl_d};
    end
  end

endmodule

@@ rtl/gcoq_checker.sv @@
// Port-level checker for the grid cell openness query block, bound to its
// top level. Depends on gcoq_pkg.
module gcoq_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [0:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [gcoq_pkg::OPN_W-1:0]    m_axis_tdata
);
  import gcoq_pkg::*;

  // A result held against a stalled sink stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // One item at a time: right after an accepted item the block is busy.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while another is in progress");

  // A write item accepted while no result is pending yields a zero result via the done state.
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_WRITE && !m_axis_tvalid
    |=> ##1 (m_axis_tvalid && m_axis_tdata == '0))
    else $error("write item did not return a zero result in time");

  // A fresh result appears together with readiness for the next item.
  a_ready_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("block not ready after delivering a result");

endmodule

bind grid_cell_openness_query gcoq_checker u_gcoq_checker (.*);
